// ----- design/lfk_pkg.sv -----
// lfk_pkg: shared types, codes and sizes of the lattice flip unit
// no dependencies; used by the interfaces, the multiplier and the top level
`default_nettype none

package lfk_pkg;

    localparam int SITES_DEF    = 4096;
    localparam int SIDE_DEF     = 64;
    localparam int RATE_W       = 16;
    localparam int RAND_W       = 32;
    localparam int MUL_W        = 32;
    localparam int SITE_OUT_W   = 12;
    localparam int WEIGHT_OUT_W = 30;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_RES      = 4;

    // register indexes of the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_B,
        REG_RATE_C,
        REG_RATE_D
    } lfk_reg_t;

    // site classes
    typedef enum logic [2:0] {
        CL_A,
        CL_B,
        CL_C,
        CL_D,
        CL_E
    } lfk_class_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WB,
        ST_WC,
        ST_WD,
        ST_WSUM,
        ST_CLS_MUL,
        ST_CLS_CMP,
        ST_ELEM_MUL,
        ST_ELEM_IDX,
        ST_MV_READ,
        ST_MV_SITE,
        ST_SW_START,
        ST_SW_WR1,
        ST_SW_WR2,
        ST_SW_NEXT,
        ST_MV_DONE,
        ST_DIV_MUL,
        ST_DIV_Y,
        ST_DIV_UP,
        ST_NB_READ,
        ST_NB_EVAL,
        ST_NB_ADV,
        ST_SEND
    } lfk_state_t;

    // operands for the shared multiplier
    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    // one result word
    typedef struct packed {
        logic [SITE_OUT_W-1:0]   site;
        logic                    new_state;
        logic                    from_b;
        logic [WEIGHT_OUT_W-1:0] total_weight;
        logic                    error;
    } res_t;

endpackage

`default_nettype wire

// ----- design/lfk_if.sv -----
// lfk_in_if / lfk_out_if: valid-ready channels of the lattice flip unit
// depends on lfk_pkg for field widths
`default_nettype none

interface lfk_in_if import lfk_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RAND_W-1:0] class_random;
    logic [RAND_W-1:0] element_random;

    modport source(output valid, output class_random, output element_random, input ready);
    modport sink(input valid, input class_random, input element_random, output ready);
endinterface

interface lfk_out_if import lfk_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SITE_OUT_W-1:0]   site;
    logic                    new_state;
    logic                    from_b;
    logic [WEIGHT_OUT_W-1:0] total_weight;
    logic                    error;
    logic                    last;

    modport source(output valid, output site, output new_state, output from_b,
                   output total_weight, output error, output last, input ready);
    modport sink(input valid, input site, input new_state, input from_b,
                 input total_weight, input error, input last, output ready);
endinterface

`default_nettype wire

// ----- design/lfk_mul.sv -----
// lfk_mul: shared 32x32 multiplier with a registered product
// depends on lfk_pkg for the operand struct
`default_nettype none

module lfk_mul import lfk_pkg::*;
(
    input  wire logic               clk,
    input  wire mul_req_t           req,
    output logic [2*MUL_W-1:0]      prod
);

    // one product per cycle, ready the cycle after the operands
    always_ff @(posedge clk)
    begin
        prod <= req.a * req.b;
    end

endmodule

`default_nettype wire

// ----- design/lattice_flip_kinetic_monte_carlo_unit.sv -----
// lattice_flip_kinetic_monte_carlo_unit: top level, sequencer, site tables and result buffer
// depends on lfk_pkg, lfk_if and lfk_mul
//
//   channel        dir  handshake      payload
//   items          in   valid/ready    class_random, element_random
//   results        out  valid/ready    site, new_state, from_b, total_weight, error, last
//   write port     in   write_enable   write_index, write_data
//
// one word in at a time; a word passes the weight sum, the class and element choice, the flip
// and up to three neighbor moves, each move swapping table entries class by class (no writes
// when the entries coincide), then sends its buffered results one by one; the pace is set by
// the single write port of the order table and the shared multiplier
// after reset a clearing pass over all SITES entries loads the tables; items waits meanwhile
// results are buffered and sent at the end; a stalled sink holds the block in send
`default_nettype none

module lattice_flip_kinetic_monte_carlo_unit import lfk_pkg::*;
#(
    parameter int SITES = SITES_DEF,
    parameter int SIDE  = SIDE_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    lfk_in_if.sink                    items,
    lfk_out_if.source                 results,
    input  wire logic                 write_enable,
    input  wire logic [CFG_IDX_W-1:0] write_index,
    input  wire logic [RATE_W-1:0]    write_data
);

    localparam int AW    = $clog2(SITES);
    localparam int CW    = $clog2(SITES + 1);
    localparam int WW    = RATE_W + AW;
    localparam int XW    = $clog2(SIDE);
    localparam int NBW   = $clog2(SITES + SIDE * SIDE);
    localparam int RIW   = $clog2(MAX_RES);
    localparam int RCW   = $clog2(MAX_RES + 1);
    localparam logic [MUL_W-1:0] RECIP = MUL_W'((64'd1 << 32) / SIDE + 64'd1);

    // control and datapath registers
    lfk_state_t            state_reg, state_next;
    logic [RATE_W-1:0]     rate_b_reg, rate_c_reg, rate_d_reg;
    logic [CW-1:0]         count_reg [5];
    logic [RAND_W-1:0]     cr_reg, er_reg;
    logic [WW-1:0]         pb_reg, pbc_reg, w_reg;
    lfk_class_t            cls_reg, init_reg, fin_reg, step_reg;
    logic                  up_reg, first_reg;
    logic [AW-1:0]         p_reg, tgt_reg, site_reg, sb_reg, y_reg, clr_reg;
    logic [XW-1:0]         x_reg;
    logic [NBW-1:0]        nb_reg [3];
    logic [1:0]            nb_k_reg;
    res_t                  res_reg [MAX_RES];
    logic [RCW-1:0]        res_cnt_reg, send_idx_reg;
    logic                  out_valid_reg, out_last_reg;
    res_t                  out_word_reg;

    // memories
    logic [AW-1:0]         order_mem [SITES];
    logic [AW-1:0]         pos_mem [SITES];
    logic [2:0]            state_mem [SITES];
    logic [AW-1:0]         order_rd, pos_rd;
    logic [2:0]            state_rd;
    logic                  order_we, pos_we, state_we;
    logic [AW-1:0]         order_wa, order_wd, order_ra, pos_wa, pos_wd, pos_ra;
    logic [AW-1:0]         state_wa, state_ra;
    logic [2:0]            state_wd;

    // shared multiplier
    mul_req_t              mul_req;
    logic [2*MUL_W-1:0]    mul_prod;

    lfk_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    // prefix counts of the class slices
    logic [CW-1:0] prefix [5];
    always_comb
    begin
        prefix[0] = '0;
        for (int i = 1; i < 5; i++)
        begin
            prefix[i] = prefix[i-1] + count_reg[i-1];
        end
    end

    // rates of the moving site's classes, zero for A and E
    logic [RATE_W-1:0] rate_init, rate_fin;
    always_comb
    begin
        unique case (init_reg)
            CL_B:    rate_init = rate_b_reg;
            CL_C:    rate_init = rate_c_reg;
            CL_D:    rate_init = rate_d_reg;
            default: rate_init = '0;
        endcase
        unique case (fin_reg)
            CL_B:    rate_fin = rate_b_reg;
            CL_C:    rate_fin = rate_c_reg;
            CL_D:    rate_fin = rate_d_reg;
            default: rate_fin = '0;
        endcase
    end

    // class choice from the scaled class fraction
    lfk_class_t cls_pick;
    always_comb
    begin
        priority if (count_reg[CL_B] != '0 && mul_prod <= (64'(pb_reg) << 32))
            cls_pick = CL_B;
        else if (count_reg[CL_C] != '0 && mul_prod <= (64'(pbc_reg) << 32))
            cls_pick = CL_C;
        else if (count_reg[CL_D] != '0 && mul_prod <= (64'(w_reg) << 32))
            cls_pick = CL_D;
        else if (count_reg[CL_B] != '0)
            cls_pick = CL_B;
        else if (count_reg[CL_C] != '0)
            cls_pick = CL_C;
        else
            cls_pick = CL_D;
    end

    // start of a move: the class pair, site and position
    lfk_class_t    bm_init, bm_fin;
    logic [AW-1:0] bm_site, bm_p;
    logic          nb_skip;
    lfk_class_t    nb_cls;
    always_comb
    begin
        nb_cls  = lfk_class_t'(state_rd);
        nb_skip = (nb_cls == CL_A) || (state_rd > 3'(CL_E));
        if (state_reg == ST_NB_EVAL)
        begin
            bm_init = nb_cls;
            bm_fin  = (nb_cls == CL_E) ? CL_A : lfk_class_t'(state_rd + 3'd1);
            bm_site = AW'(nb_reg[nb_k_reg]);
            bm_p    = pos_rd;
        end
        else
        begin
            bm_init = init_reg;
            bm_fin  = fin_reg;
            bm_site = order_rd;
            bm_p    = p_reg;
        end
    end

    logic bm_emit;
    res_t bm_word;
    assign bm_emit = (bm_fin == CL_A) || (bm_fin == CL_E);
    always_comb
    begin
        bm_word.site         = SITE_OUT_W'(bm_site);
        bm_word.new_state    = (bm_fin == CL_E);
        bm_word.from_b       = (bm_init == CL_B);
        bm_word.total_weight = WEIGHT_OUT_W'(w_reg);
        bm_word.error        = 1'b0;
    end

    // neighbour positions from the row and column of the flipped site
    logic [AW-1:0]  y_now, ym;
    logic [XW-1:0]  xp1, xm1;
    logic [NBW-1:0] nb_up, nb_down, nb_row;
    always_comb
    begin
        y_now   = mul_prod[MUL_W +: AW];
        ym      = AW'(({1'b0, y_reg} + 1'b1) - AW'(mul_prod[MUL_W +: AW] * SIDE));
        xp1     = (32'(x_reg) == SIDE - 1) ? '0 : x_reg + 1'b1;
        xm1     = (x_reg == '0) ? '0 : x_reg - 1'b1;
        nb_row  = NBW'(y_reg * SIDE);
        nb_up   = NBW'(ym * SIDE) + NBW'(x_reg);
        nb_down = NBW'(((y_reg == '0) ? '0 : y_reg - 1'b1) * SIDE) + NBW'(x_reg);
    end

    logic out_free;
    assign out_free = !out_valid_reg || results.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (32'(clr_reg) == SITES - 1) state_next = ST_IDLE;
            ST_IDLE:     if (items.valid) state_next = ST_WB;
            ST_WB:       state_next = ST_WC;
            ST_WC:       state_next = ST_WD;
            ST_WD:       state_next = ST_WSUM;
            ST_WSUM:     state_next = ((pbc_reg + WW'(mul_prod)) == '0) ? ST_SEND : ST_CLS_MUL;
            ST_CLS_MUL:  state_next = ST_CLS_CMP;
            ST_CLS_CMP:  state_next = ST_ELEM_MUL;
            ST_ELEM_MUL: state_next = ST_ELEM_IDX;
            ST_ELEM_IDX: state_next = ST_MV_READ;
            ST_MV_READ:  state_next = ST_MV_SITE;
            ST_MV_SITE:  state_next = ST_SW_START;
            ST_SW_START: state_next = (p_reg == tgt_reg) ? ST_SW_NEXT : ST_SW_WR1;
            ST_SW_WR1:   state_next = ST_SW_WR2;
            ST_SW_WR2:   state_next = ST_SW_NEXT;
            ST_SW_NEXT:  state_next = (up_reg || step_reg == fin_reg) ? ST_MV_DONE : ST_SW_START;
            ST_MV_DONE:  state_next = first_reg ? ST_DIV_MUL : ST_NB_ADV;
            ST_DIV_MUL:  state_next = ST_DIV_Y;
            ST_DIV_Y:    state_next = ST_DIV_UP;
            ST_DIV_UP:   state_next = ST_NB_READ;
            ST_NB_READ:
                state_next = (32'(nb_reg[nb_k_reg]) >= SITES) ? ST_NB_ADV : ST_NB_EVAL;
            ST_NB_EVAL:  state_next = nb_skip ? ST_NB_ADV : ST_SW_START;
            ST_NB_ADV:   state_next = (nb_k_reg == 2'd2) ? ST_SEND : ST_NB_READ;
            ST_SEND:
                if (out_free && send_idx_reg == res_cnt_reg - 1'b1) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake, multiplier operands, memory ports
    always_comb
    begin
        items.ready = (state_reg == ST_IDLE);
        mul_req     = '0;
        order_we    = 1'b0;
        order_wa    = p_reg;
        order_wd    = site_reg;
        order_ra    = p_reg;
        pos_we      = 1'b0;
        pos_wa      = site_reg;
        pos_wd      = tgt_reg;
        pos_ra      = AW'(nb_reg[nb_k_reg]);
        state_we    = 1'b0;
        state_wa    = site_reg;
        state_wd    = fin_reg;
        state_ra    = AW'(nb_reg[nb_k_reg]);
        unique case (state_reg)
            ST_CLEAR:
            begin
                order_we = 1'b1;
                order_wa = clr_reg;
                order_wd = clr_reg;
                pos_we   = 1'b1;
                pos_wa   = clr_reg;
                pos_wd   = clr_reg;
                state_we = 1'b1;
                state_wa = clr_reg;
                state_wd = CL_B;
            end
            ST_WB:       mul_req = '{a: MUL_W'(rate_b_reg), b: MUL_W'(count_reg[CL_B])};
            ST_WC:       mul_req = '{a: MUL_W'(rate_c_reg), b: MUL_W'(count_reg[CL_C])};
            ST_WD:       mul_req = '{a: MUL_W'(rate_d_reg), b: MUL_W'(count_reg[CL_D])};
            ST_CLS_MUL:  mul_req = '{a: cr_reg, b: MUL_W'(w_reg)};
            ST_ELEM_MUL: mul_req = '{a: er_reg, b: MUL_W'(count_reg[cls_reg])};
            ST_DIV_MUL:  mul_req = '{a: MUL_W'(site_reg), b: RECIP};
            ST_DIV_Y:    mul_req = '{a: MUL_W'({1'b0, y_now} + 1'b1), b: RECIP};
            ST_SW_START: order_ra = tgt_reg;
            ST_SW_WR1:
            begin
                order_we = 1'b1;
                order_wa = p_reg;
                order_wd = order_rd;
                pos_we   = 1'b1;
                pos_wa   = site_reg;
                pos_wd   = tgt_reg;
            end
            ST_SW_WR2:
            begin
                order_we = 1'b1;
                order_wa = tgt_reg;
                order_wd = site_reg;
                pos_we   = 1'b1;
                pos_wa   = sb_reg;
                pos_wd   = p_reg;
            end
            ST_MV_DONE:  state_we = 1'b1;
            default:     ;
        endcase
    end

    // site tables
    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[order_wa] <= order_wd;
        end
        if (pos_we)
        begin
            pos_mem[pos_wa] <= pos_wd;
        end
        if (state_we)
        begin
            state_mem[state_wa] <= state_wd;
        end
        order_rd <= order_mem[order_ra];
        pos_rd   <= pos_mem[pos_ra];
        state_rd <= state_mem[state_ra];
    end

    // control registers, counts and rates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rate_b_reg    <= RATE_W'(1);
            rate_c_reg    <= RATE_W'(1);
            rate_d_reg    <= RATE_W'(1);
            for (int i = 0; i < 5; i++)
            begin
                count_reg[i] <= (i == int'(CL_B)) ? CW'(SITES) : '0;
            end
            res_cnt_reg   <= '0;
            send_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            nb_k_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (write_enable)
            begin
                unique case (write_index)
                    REG_RATE_B: rate_b_reg <= write_data;
                    REG_RATE_C: rate_c_reg <= write_data;
                    REG_RATE_D: rate_d_reg <= write_data;
                    default:    ;
                endcase
            end
            // result valid: set on each send, cleared once taken
            if (state_reg == ST_SEND && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE:
                    if (items.valid)
                    begin
                        res_cnt_reg  <= '0;
                        send_idx_reg <= '0;
                    end
                ST_WSUM:
                    if ((pbc_reg + WW'(mul_prod)) == '0)
                    begin
                        res_cnt_reg <= RCW'(1);
                    end
                ST_ELEM_IDX: first_reg <= 1'b1;
                ST_MV_SITE:
                    if (bm_emit)
                    begin
                        res_cnt_reg <= res_cnt_reg + 1'b1;
                    end
                ST_NB_EVAL:
                    if (!nb_skip && bm_emit)
                    begin
                        res_cnt_reg <= res_cnt_reg + 1'b1;
                    end
                ST_MV_DONE:
                begin
                    count_reg[init_reg] <= count_reg[init_reg] - 1'b1;
                    count_reg[fin_reg]  <= count_reg[fin_reg] + 1'b1;
                    first_reg           <= 1'b0;
                end
                ST_DIV_UP: nb_k_reg <= '0;
                ST_NB_ADV: nb_k_reg <= nb_k_reg + 1'b1;
                ST_SEND:
                    if (out_free)
                    begin
                        send_idx_reg  <= send_idx_reg + 1'b1;
                    end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cr_reg <= items.class_random;
                er_reg <= items.element_random;
            end
            ST_WC: pb_reg  <= WW'(mul_prod);
            ST_WD: pbc_reg <= pb_reg + WW'(mul_prod);
            ST_WSUM:
            begin
                w_reg      <= pbc_reg + WW'(mul_prod);
                res_reg[0] <= '{site: '0, new_state: 1'b0, from_b: 1'b0,
                                total_weight: '0, error: 1'b1};
            end
            ST_CLS_CMP: cls_reg <= cls_pick;
            ST_ELEM_IDX:
            begin
                p_reg    <= AW'(prefix[cls_reg] + CW'(mul_prod[MUL_W +: CW]));
                init_reg <= cls_reg;
                fin_reg  <= CL_A;
            end
            ST_MV_SITE, ST_NB_EVAL:
            begin
                init_reg <= bm_init;
                fin_reg  <= bm_fin;
                site_reg <= bm_site;
                p_reg    <= bm_p;
                up_reg   <= (bm_init < bm_fin);
                step_reg <= lfk_class_t'(bm_init - 3'd1);
                if (bm_init < bm_fin)
                begin
                    tgt_reg <= AW'(prefix[bm_init] + count_reg[bm_init] - 1'b1);
                end
                else
                begin
                    tgt_reg <= AW'(prefix[bm_init]);
                end
                if (bm_emit)
                begin
                    res_reg[res_cnt_reg[RIW-1:0]] <= bm_word;
                end
            end
            ST_SW_WR1: sb_reg <= order_rd;
            ST_SW_NEXT:
                if (!(up_reg || step_reg == fin_reg))
                begin
                    p_reg    <= tgt_reg;
                    tgt_reg  <= tgt_reg - AW'(count_reg[step_reg]);
                    step_reg <= lfk_class_t'(step_reg - 3'd1);
                end
            ST_MV_DONE:
                w_reg <= WW'(({1'b0, w_reg} + (WW + 1)'(rate_fin)) - (WW + 1)'(rate_init));
            ST_DIV_Y:
            begin
                y_reg <= y_now;
                x_reg <= XW'(site_reg - AW'(y_now * SIDE));
            end
            ST_DIV_UP:
            begin
                nb_reg[0] <= nb_row + NBW'(xp1);
                nb_reg[1] <= nb_row + NBW'(xm1);
                nb_reg[2] <= (x_reg[0] == y_reg[0]) ? nb_up : nb_down;
            end
            ST_SEND:
                if (out_free)
                begin
                    out_word_reg <= res_reg[send_idx_reg[RIW-1:0]];
                    out_last_reg <= (send_idx_reg == res_cnt_reg - 1'b1);
                end
            default: ;
        endcase
    end

    // result port
    assign results.valid        = out_valid_reg;
    assign results.site         = out_word_reg.site;
    assign results.new_state    = out_word_reg.new_state;
    assign results.from_b       = out_word_reg.from_b;
    assign results.total_weight = out_word_reg.total_weight;
    assign results.error        = out_word_reg.error;
    assign results.last         = out_last_reg;

endmodule

`default_nettype wire

// ----- tb/sv/lfk_tb_if.sv -----
// lfk_tb_if: no extra interfaces are needed beside the design's own channels
// depends on lfk_pkg; holds only the result record the scoreboard keeps
`default_nettype none

package lfk_tb_pkg;
    import lfk_pkg::*;

    // one expected result word
    typedef struct packed {
        logic [SITE_OUT_W-1:0]   site;
        logic                    new_state;
        logic                    from_b;
        logic [WEIGHT_OUT_W-1:0] total_weight;
        logic                    error;
        logic                    last;
    } flip_word_t;
endpackage

`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: lattice flip unit testbench; predicts flips and neighbour moves per input word
// depends on lfk_pkg, lfk_tb_pkg, lfk_if and the top level design
`default_nettype none

module tb;
    import lfk_pkg::*;
    import lfk_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NS = SITES_DEF;
    localparam int SD = SIDE_DEF;

    // scoreboard: lattice predictor and queue of expected words
    class flip_board;
        logic [15:0] rate[1:3];
        logic [2:0]  cls_of[NS];
        int          order_t[NS];
        int          pos_t[NS];
        int          cnt[5];
        flip_word_t  pending[$];
        int          bad;

        function void clear();
            for (int i = 0; i < NS; i++)
            begin
                cls_of[i] = CL_B; order_t[i] = i; pos_t[i] = i;
            end
            for (int i = 0; i < 5; i++) cnt[i] = 0;
            cnt[CL_B] = NS;
            for (int k = 1; k <= 3; k++) rate[k] = 16'd1;
            bad = 0;
        endfunction

        function longint weight();
            return longint'(rate[1]) * cnt[1] + longint'(rate[2]) * cnt[2]
                 + longint'(rate[3]) * cnt[3];
        endfunction

        function int base(int k);
            int s;
            s = 0;
            for (int i = 0; i < k; i++) s += cnt[i];
            return s;
        endfunction

        function void swap_at(int a, int b);
            int sa, sb, t;
            if (a == b || a < 0 || b < 0 || a >= NS || b >= NS) return;
            sa = order_t[a]; sb = order_t[b];
            t = pos_t[sa]; pos_t[sa] = pos_t[sb]; pos_t[sb] = t;
            order_t[a] = sb; order_t[b] = sa;
        endfunction

        // move one element between classes, noting moves into A or E
        function int shift(int from, int idx, int to);
            int p, s, fp;
            flip_word_t w;
            p = base(from) + idx;
            if (p >= NS) return 0;
            s = order_t[p];
            if (to == CL_A || to == CL_E)
            begin
                w = '0;
                w.site = s[11:0];
                w.new_state = (to == CL_E);
                w.from_b = (from == CL_B);
                w.total_weight = WEIGHT_OUT_W'(weight());
                pending.push_back(w);
            end
            if (from < to)
                swap_at(p, base(from) + cnt[from] - 1);
            else
            begin
                fp = base(from);
                for (int i = from - 1; i >= to; i--)
                begin
                    swap_at(p, fp);
                    p = fp;
                    fp -= cnt[i];
                end
            end
            cnt[from]--; cnt[to]++;
            cls_of[s] = 3'(to);
            return s;
        endfunction

        function void note_word(logic [31:0] cr, logic [31:0] er);
            longint unsigned w, cum;
            int k, s, x, y, st, n0;
            int nb[3];
            flip_word_t e;
            w = weight();
            n0 = pending.size();
            if (w == 0)
            begin
                e = '0; e.error = 1; e.last = 1;
                pending.push_back(e);
                return;
            end
            k = 0; cum = 0;
            for (int c = 1; c <= 3 && k == 0; c++)
            begin
                cum += longint'(rate[c]) * cnt[c];
                if (cnt[c] > 0 && {64'd0, cr} * w <= {32'd0, cum, 32'd0}) k = c;
            end
            if (k == 0)
                for (int c = 3; c >= 1; c--) if (cnt[c] > 0) k = c;
            s = shift(k, int'(({32'd0, er} * cnt[k]) >> 32), CL_A);
            x = s % SD; y = s / SD;
            nb[0] = SD * y + (x + 1) % SD;
            nb[1] = SD * y + (x > 0 ? x - 1 : 0);
            nb[2] = ((x & 1) == (y & 1)) ? SD * ((y + 1) % SD) + x
                                         : SD * (y > 0 ? y - 1 : 0) + x;
            for (int j = 0; j < 3; j++)
            begin
                st = cls_of[nb[j]];
                if (st == CL_A) continue;
                void'(shift(st, pos_t[nb[j]] - base(st), st == CL_E ? CL_A : st + 1));
            end
            if (pending.size() > n0) pending[pending.size() - 1].last = 1;
        endfunction

        function void check_word(flip_word_t got);
            flip_word_t want;
            if (pending.size() == 0)
            begin
                bad++;
                if (bad <= 10) $display("unexpected word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                bad++;
                if (bad <= 10)
                    $display("mismatch exp site=%0d ns=%b b=%b w=%0d err=%b last=%b,",
                             want.site, want.new_state, want.from_b, want.total_weight,
                             want.error, want.last,
                             " got site=%0d ns=%b b=%b w=%0d err=%b last=%b",
                             got.site, got.new_state, got.from_b,
                             got.total_weight, got.error, got.last);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic write_enable = 0;
    logic [CFG_IDX_W-1:0] write_index = '0;
    logic [RATE_W-1:0] write_data = '0;
    int send_idle = 0;
    int recv_stall = 0;
    bit stim_done = 0;

    lfk_in_if  items();
    lfk_out_if results();

    lattice_flip_kinetic_monte_carlo_unit u_top (
        .clk(clk), .rst_n(rst_n), .items(items.sink), .results(results.source),
        .write_enable(write_enable), .write_index(write_index), .write_data(write_data)
    );

    flip_board board = new();

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        items.valid = 0; items.class_random = '0; items.element_random = '0;
        results.ready = 0;
        board.clear();
    end

    // receiver: random stall, check each accepted word
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
            board.check_word({results.site, results.new_state, results.from_b,
                              results.total_weight, results.error, results.last});
        results.ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic set_rate(lfk_reg_t idx, logic [15:0] v);
        @(posedge clk);
        write_enable <= 1; write_index <= idx; write_data <= v;
        @(posedge clk);
        write_enable <= 0;
        board.rate[int'(idx) + 1] = v;
    endtask

    // wait for drain plus latency slack before touching registers
    task automatic drain();
        items.valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_word(logic [31:0] cr, logic [31:0] er);
        while ($urandom_range(99) < send_idle)
        begin
            items.valid <= 0;
            @(posedge clk);
        end
        items.valid <= 1; items.class_random <= cr; items.element_random <= er;
        @(posedge clk);
        while (!items.ready) @(posedge clk);
        board.note_word(cr, er);
    endtask

    task automatic random_words(int n);
        logic [31:0] v[2];
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < 2; j++)
                case ($urandom_range(5))
                    0: v[j] = 32'd0;
                    1: v[j] = 32'hFFFF_FFFF;
                    default: v[j] = $urandom;
                endcase
            send_word(v[0], v[1]);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        // directed: field extremes at reset rates
        send_word(32'd0, 32'd0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h8000_0000, 32'h0000_0001);
        send_word(32'h0000_0001, 32'h8000_0000);
        send_word(32'hFFFF_FFFF, 32'd0);
        send_word(32'd0, 32'hFFFF_FFFF);
        drain();
        // zero weight gives an error word
        set_rate(REG_RATE_B, 16'd0); set_rate(REG_RATE_C, 16'd0);
        set_rate(REG_RATE_D, 16'd0);
        send_word(32'h1234_5678, 32'h9ABC_DEF0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        set_rate(REG_RATE_B, 16'hFFFF); set_rate(REG_RATE_C, 16'hFFFF);
        set_rate(REG_RATE_D, 16'hFFFF);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'd0, 32'd0);
        drain();
        // random phases across idling patterns and rate settings
        set_rate(REG_RATE_B, 16'd1); set_rate(REG_RATE_C, 16'd40000);
        set_rate(REG_RATE_D, 16'd3);
        random_words(25);
        drain();
        send_idle = 86;
        set_rate(REG_RATE_B, 16'd0); set_rate(REG_RATE_C, 16'hFFFF);
        set_rate(REG_RATE_D, 16'd0);
        random_words(25);
        drain();
        send_idle = 0; recv_stall = 86;
        set_rate(REG_RATE_B, 16'($urandom)); set_rate(REG_RATE_C, 16'($urandom));
        set_rate(REG_RATE_D, 16'($urandom));
        random_words(25);
        drain();
        send_idle = 23; recv_stall = 23;
        set_rate(REG_RATE_B, 16'd7); set_rate(REG_RATE_C, 16'd0);
        set_rate(REG_RATE_D, 16'hFFFF);
        random_words(25);
        drain();
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        if (board.bad == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire
